// ----- design/saa_pkg.sv -----
// Shared constants and controller/datapath interface types for the skyline atlas allocator.
// Used by saa_ctrl, saa_dp and skyline_atlas_allocator; depends on nothing.
`default_nettype none

package saa_pkg;

	localparam int PAGES   = 2;
	localparam int COLUMNS = 256;
	localparam int ROWS    = 256;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int PG_W   = 1;
	localparam int HT_W   = 9;
	localparam int DIM_W  = 9;
	localparam int POS_W  = 8;
	localparam int ADDR_W = $clog2(PAGES * COLUMNS);
	localparam int SUM_W  = DIM_W + 1;

	// Request codes.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// Result status codes.
	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FULL = 1'b1;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic fwd_start;
		logic fwd_step;
		logic bwd_start;
		logic bwd_step;
		logic next_page;
		logic wr_start;
		logic wr_step;
		logic res_full;
		logic res_place;
		logic res_clear;
	} dp_cmd_t;

	typedef struct packed {
		logic shape_ok;
		logic idx_end;
		logic idx_zero;
		logic fits;
		logic page_last;
		logic clr_last;
		logic wr_last;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- design/saa_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module saa_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- design/saa_ctrl.sv -----
// Sequencing state machine of the skyline atlas allocator.
// Depends on saa_pkg for the datapath command and status structs.
`default_nettype none

module saa_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 req_type,
	input  wire saa_pkg::dp_status_t  st,
	output saa_pkg::dp_cmd_t          cmd,
	output logic                      busy,
	output logic                      done
);

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_CLEAR   = 9'b000000010,
		ST_PAGE    = 9'b000000100,
		ST_FWD     = 9'b000001000,
		ST_FWD_END = 9'b000010000,
		ST_BWD     = 9'b000100000,
		ST_BWD_END = 9'b001000000,
		ST_EVAL    = 9'b010000000,
		ST_WRITE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   reply_q;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (req_type == saa_pkg::REQ_CLEAR) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_PAGE;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					cmd.res_clear = reply_q;
					state_d       = ST_IDLE;
				end
			end
			ST_PAGE: begin
				if (!st.shape_ok) begin
					cmd.res_full = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.fwd_start = 1'b1;
					state_d       = ST_FWD;
				end
			end
			ST_FWD: begin
				cmd.fwd_step = 1'b1;
				if (st.idx_end) begin
					state_d = ST_FWD_END;
				end
			end
			ST_FWD_END: begin
				cmd.bwd_start = 1'b1;
				state_d       = ST_BWD;
			end
			ST_BWD: begin
				cmd.bwd_step = 1'b1;
				if (st.idx_zero) begin
					state_d = ST_BWD_END;
				end
			end
			ST_BWD_END: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (st.fits) begin
					cmd.wr_start = 1'b1;
					state_d      = ST_WRITE;
				end else if (st.page_last) begin
					cmd.res_full = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.next_page = 1'b1;
					state_d       = ST_PAGE;
				end
			end
			ST_WRITE: begin
				cmd.wr_step = 1'b1;
				if (st.wr_last) begin
					cmd.res_place = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The clearing pass after reset gives no result; a clear request does.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			reply_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.res_full | cmd.res_place | cmd.res_clear;
			if (cmd.load) begin
				reply_q <= 1'b1;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

// ----- design/saa_dp.sv -----
// Datapath of the skyline atlas allocator: height and prefix-maximum memories,
// scan counters, window-maximum search and result registers.
// Depends on saa_pkg and saa_ram.
`default_nettype none

module saa_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire saa_pkg::dp_cmd_t             cmd,
	input  wire logic [saa_pkg::DIM_W-1:0]    rect_width,
	input  wire logic [saa_pkg::DIM_W-1:0]    rect_height,
	output saa_pkg::dp_status_t               st,
	output logic                              status,
	output logic [saa_pkg::PG_W-1:0]          page,
	output logic [saa_pkg::POS_W-1:0]         pos_x,
	output logic [saa_pkg::POS_W-1:0]         pos_y
);

	localparam int COL_W  = saa_pkg::COL_W;
	localparam int HT_W   = saa_pkg::HT_W;
	localparam int DIM_W  = saa_pkg::DIM_W;
	localparam int ADDR_W = saa_pkg::ADDR_W;
	localparam int SUM_W  = saa_pkg::SUM_W;
	localparam int PG_W   = saa_pkg::PG_W;
	localparam int POS_W  = saa_pkg::POS_W;

	// Request and scan state.
	logic [DIM_W-1:0]  req_w_q, req_h_q;
	logic [PG_W-1:0]   page_q;
	logic [COL_W-1:0]  idx_q;
	logic [COL_W-1:0]  mod_q;
	logic [HT_W-1:0]   run_q;
	logic [HT_W-1:0]   best_q;
	logic [COL_W-1:0]  bestx_q;
	logic              found_q;
	logic [ADDR_W-1:0] clr_q;
	logic [COL_W-1:0]  wcol_q;
	logic [DIM_W-1:0]  wrem_q;
	logic [HT_W-1:0]   wval_q;

	// Read in flight.
	logic              v_s1;
	logic              bwd_s1;
	logic              restart_s1;
	logic              eval_s1;
	logic [COL_W-1:0]  idx_s1;
	logic [COL_W-1:0]  mod_s1;

	// Result registers.
	logic              res_status_q;
	logic [PG_W-1:0]   res_page_q;
	logic [POS_W-1:0]  res_x_q, res_y_q;

	logic [COL_W-1:0]  wm1;
	logic [ADDR_W-1:0] page_base;
	logic [ADDR_W-1:0] ht_waddr, ht_raddr;
	logic [HT_W-1:0]   ht_wdata, ht_rdata;
	logic              ht_we;
	logic [COL_W-1:0]  pf_raddr;
	logic [HT_W-1:0]   pf_rdata;
	logic              pf_we;
	logic [HT_W-1:0]   run_new, wmax;
	logic              cand;
	logic              restart_now, eval_now;
	logic [SUM_W-1:0]  idx_plus_w;
	logic [SUM_W-1:0]  top_sum;

	assign wm1        = req_w_q[COL_W-1:0] - COL_W'(1);
	assign page_base  = ADDR_W'(page_q) * ADDR_W'(saa_pkg::COLUMNS);
	assign idx_plus_w = SUM_W'(idx_q) + SUM_W'(req_w_q);
	assign top_sum    = SUM_W'(best_q) + SUM_W'(req_h_q);

	// Heights memory: written by the clearing pass and the column raise.
	assign ht_we    = cmd.clr_step | cmd.wr_step;
	assign ht_waddr = cmd.clr_step ? clr_q : (page_base + ADDR_W'(wcol_q));
	assign ht_wdata = cmd.clr_step ? '0 : wval_q;
	assign ht_raddr = page_base + ADDR_W'(idx_q);

	// Prefix maxima, restarted at each block of width w, from the forward pass.
	assign pf_we    = v_s1 & ~bwd_s1;
	assign pf_raddr = COL_W'(idx_plus_w - SUM_W'(1));

	saa_ram #(.WIDTH(HT_W), .DEPTH(saa_pkg::PAGES * saa_pkg::COLUMNS)) u_heights (
		.clk   (clk),
		.we    (ht_we),
		.waddr (ht_waddr),
		.wdata (ht_wdata),
		.raddr (ht_raddr),
		.rdata (ht_rdata)
	);

	saa_ram #(.WIDTH(HT_W), .DEPTH(saa_pkg::COLUMNS)) u_prefix (
		.clk   (clk),
		.we    (pf_we),
		.waddr (idx_s1),
		.wdata (run_new),
		.raddr (pf_raddr),
		.rdata (pf_rdata)
	);

	// A block restarts at a multiple of w going forward; going backward the
	// suffix maximum restarts at a block's last column or the page's last column.
	always_comb begin
		if (cmd.bwd_step) begin
			restart_now = (mod_q == wm1) || (idx_q == COL_W'(saa_pkg::COLUMNS - 1));
		end else begin
			restart_now = (mod_q == '0);
		end
		eval_now = (idx_plus_w <= SUM_W'(saa_pkg::COLUMNS));
	end

	// Window maximum at start s is max(suffix[s], prefix[s+w-1]).
	always_comb begin
		if (restart_s1 || (ht_rdata > run_q)) begin
			run_new = ht_rdata;
		end else begin
			run_new = run_q;
		end
		wmax = (pf_rdata > run_new) ? pf_rdata : run_new;
		// The backward scan visits windows right to left, so ties go to the later one.
		cand = v_s1 && bwd_s1 && eval_s1 && (wmax < HT_W'(saa_pkg::ROWS))
			&& (!found_q || (wmax <= best_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= cmd.fwd_step | cmd.bwd_step;
			if (cmd.clr_step) begin
				if (clr_q == ADDR_W'(saa_pkg::PAGES * saa_pkg::COLUMNS - 1)) begin
					clr_q <= '0;
				end else begin
					clr_q <= clr_q + ADDR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_w_q <= rect_width;
			req_h_q <= rect_height;
			page_q  <= '0;
		end
		if (cmd.next_page) begin
			page_q <= page_q + PG_W'(1);
		end

		if (cmd.fwd_start) begin
			idx_q <= '0;
			mod_q <= '0;
		end else if (cmd.fwd_step) begin
			idx_q <= idx_q + COL_W'(1);
			mod_q <= (mod_q == wm1) ? '0 : (mod_q + COL_W'(1));
		end else if (cmd.bwd_start) begin
			idx_q <= COL_W'(saa_pkg::COLUMNS - 1);
			mod_q <= mod_s1;
		end else if (cmd.bwd_step) begin
			idx_q <= idx_q - COL_W'(1);
			mod_q <= (mod_q == '0) ? wm1 : (mod_q - COL_W'(1));
		end

		if (cmd.fwd_step || cmd.bwd_step) begin
			bwd_s1     <= cmd.bwd_step;
			restart_s1 <= restart_now;
			eval_s1    <= eval_now;
			idx_s1     <= idx_q;
			mod_s1     <= mod_q;
		end

		if (v_s1) begin
			run_q <= run_new;
		end

		if (cmd.fwd_start) begin
			found_q <= 1'b0;
		end else if (cand) begin
			found_q <= 1'b1;
			best_q  <= wmax;
			bestx_q <= idx_s1;
		end

		if (cmd.wr_start) begin
			wcol_q <= bestx_q;
			wrem_q <= req_w_q;
			wval_q <= top_sum[HT_W-1:0];
		end else if (cmd.wr_step) begin
			wcol_q <= wcol_q + COL_W'(1);
			wrem_q <= wrem_q - DIM_W'(1);
		end

		if (cmd.res_full) begin
			res_status_q <= saa_pkg::STAT_FULL;
			res_page_q   <= '0;
			res_x_q      <= '0;
			res_y_q      <= '0;
		end else if (cmd.res_clear) begin
			res_status_q <= saa_pkg::STAT_OK;
			res_page_q   <= '0;
			res_x_q      <= '0;
			res_y_q      <= '0;
		end else if (cmd.res_place) begin
			res_status_q <= saa_pkg::STAT_OK;
			res_page_q   <= page_q;
			res_x_q      <= POS_W'(bestx_q);
			res_y_q      <= best_q[POS_W-1:0];
		end
	end

	always_comb begin
		st.shape_ok  = (req_w_q != '0) && (req_h_q != '0)
			&& (SUM_W'(req_w_q) <= SUM_W'(saa_pkg::COLUMNS));
		st.idx_end   = (idx_q == COL_W'(saa_pkg::COLUMNS - 1));
		st.idx_zero  = (idx_q == '0);
		st.fits      = found_q && (top_sum <= SUM_W'(saa_pkg::ROWS));
		st.page_last = (page_q == PG_W'(saa_pkg::PAGES - 1));
		st.clr_last  = (clr_q == ADDR_W'(saa_pkg::PAGES * saa_pkg::COLUMNS - 1));
		st.wr_last   = (wrem_q == DIM_W'(1));
	end

	assign status = res_status_q;
	assign page   = res_page_q;
	assign pos_x  = res_x_q;
	assign pos_y  = res_y_q;

endmodule

`default_nettype wire

// ----- design/skyline_atlas_allocator.sv -----
// Top level of the skyline atlas allocator: controller plus datapath.
// Depends on saa_pkg, saa_ctrl, saa_dp and saa_ram.
//
// Usage: raise start with req_type, rect_width and rect_height; the item is
// taken at a clock edge where start is high and busy is low. req_type 0 asks
// for a rectangle, req_type 1 clears every page. One result comes back per
// item: done is high for exactly one cycle with status, page, pos_x and pos_y.
// The receiver cannot hold results off, and none is needed: only one item is
// in flight and busy stays high until its result is registered.
// Each page tried takes a forward pass over the 256 columns filling the
// prefix-maximum memory, a backward pass forming window maxima, and the
// PAGE, FWD_END, BWD_END and EVAL control states, paced by the single read
// port of the height memory. A placement then raises w columns at one per
// cycle. A full answer comes after both pages are tried; a bad shape is
// answered from the page check, with no scan.
// A clear request walks all 512 heights, one per cycle, and then answers.
// Reset: a clearing pass zeroes every height; busy is high during
// that pass, which produces no result.
`default_nettype none

module skyline_atlas_allocator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       req_type,
	input  wire logic [saa_pkg::DIM_W-1:0]  rect_width,
	input  wire logic [saa_pkg::DIM_W-1:0]  rect_height,
	output logic                            done,
	output logic                            status,
	output logic [saa_pkg::PG_W-1:0]        page,
	output logic [saa_pkg::POS_W-1:0]       pos_x,
	output logic [saa_pkg::POS_W-1:0]       pos_y
);

	saa_pkg::dp_cmd_t    cmd;
	saa_pkg::dp_status_t st;

	saa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	saa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.st          (st),
		.status      (status),
		.page        (page),
		.pos_x       (pos_x),
		.pos_y       (pos_y)
	);

endmodule

`default_nettype wire

// ----- bench/skyline_atlas_allocator_tb.sv -----
// Self-checking testbench for skyline_atlas_allocator: directed shape, window and clear items,
// then random allocate/clear traffic checked against a skyline placement predictor.
// Depends on saa_pkg and the skyline_atlas_allocator RTL.
`timescale 1ns / 1ps

module skyline_atlas_allocator_tb;

	typedef struct packed {
		logic                        status;
		logic [saa_pkg::PG_W-1:0]    page;
		logic [saa_pkg::POS_W-1:0]   pos_x;
		logic [saa_pkg::POS_W-1:0]   pos_y;
	} answer_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        req_type = saa_pkg::REQ_ALLOC;
	logic [saa_pkg::DIM_W-1:0]   rect_width = '0;
	logic [saa_pkg::DIM_W-1:0]   rect_height = '0;
	logic                        busy;
	logic                        done;
	logic                        status;
	logic [saa_pkg::PG_W-1:0]    page;
	logic [saa_pkg::POS_W-1:0]   pos_x;
	logic [saa_pkg::POS_W-1:0]   pos_y;

	logic [saa_pkg::HT_W-1:0]    col_height [saa_pkg::PAGES][saa_pkg::COLUMNS];
	answer_t                     pending_answers [$];
	answer_t                     oldest_answer;
	int                          mismatches = 0;
	int                          sender_idle_pct = 0;

	skyline_atlas_allocator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.done        (done),
		.status      (status),
		.page        (page),
		.pos_x       (pos_x),
		.pos_y       (pos_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void clear_skyline();
		for (int p = 0; p < saa_pkg::PAGES; p++)
			for (int c = 0; c < saa_pkg::COLUMNS; c++)
				col_height[p][c] = '0;
	endfunction

	// Lowest-top window search per page, leftmost on a tie, the rightmost window included.
	function automatic answer_t skyline_place(input logic req,
			input logic [saa_pkg::DIM_W-1:0] w, input logic [saa_pkg::DIM_W-1:0] h);
		answer_t ans;
		int lowest;
		int top;
		int found_x;
		bit found;
		bit ok;
		ans = '0;
		ans.status = saa_pkg::STAT_OK;
		if (req == saa_pkg::REQ_CLEAR) begin
			clear_skyline();
			return ans;
		end
		if (w != 0 && h != 0 && w <= saa_pkg::COLUMNS) begin
			for (int p = 0; p < saa_pkg::PAGES; p++) begin
				lowest = saa_pkg::ROWS;
				found_x = 0;
				found = 1'b0;
				for (int s = 0; s + w <= saa_pkg::COLUMNS; s++) begin
					top = 0;
					ok = 1'b1;
					for (int k = 0; k < w; k++) begin
						if (col_height[p][s + k] >= lowest) begin
							ok = 1'b0;
							break;
						end
						if (col_height[p][s + k] > top)
							top = col_height[p][s + k];
					end
					if (ok) begin
						lowest = top;
						found_x = s;
						found = 1'b1;
					end
				end
				if (found && lowest + h <= saa_pkg::ROWS) begin
					for (int k = 0; k < w; k++)
						col_height[p][found_x + k] = saa_pkg::HT_W'(lowest + h);
					ans.page = saa_pkg::PG_W'(p);
					ans.pos_x = saa_pkg::POS_W'(found_x);
					ans.pos_y = saa_pkg::POS_W'(lowest);
					return ans;
				end
			end
		end
		ans.status = saa_pkg::STAT_FULL;
		return ans;
	endfunction

	// The prediction is made at the accepting edge, before any result of this item can appear.
	task automatic send_item(input logic req, input logic [saa_pkg::DIM_W-1:0] w,
			input logic [saa_pkg::DIM_W-1:0] h);
		while ($urandom_range(99) < sender_idle_pct)
			@(negedge clk);
		@(negedge clk);
		start <= 1'b1;
		req_type <= req;
		rect_width <= w;
		rect_height <= h;
		do
			@(posedge clk);
		while (busy);
		pending_answers.push_back(skyline_place(req, w, h));
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_for_answers();
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				flag_mismatch("result with no item waiting");
			end else begin
				oldest_answer = pending_answers.pop_front();
				if (status !== oldest_answer.status)
					flag_mismatch($sformatf("status %0b, expected %0b", status,
						oldest_answer.status));
				if (page !== oldest_answer.page)
					flag_mismatch($sformatf("page %0d, expected %0d", page,
						oldest_answer.page));
				if (pos_x !== oldest_answer.pos_x)
					flag_mismatch($sformatf("pos_x %0d, expected %0d", pos_x,
						oldest_answer.pos_x));
				if (pos_y !== oldest_answer.pos_y)
					flag_mismatch($sformatf("pos_y %0d, expected %0d", pos_y,
						oldest_answer.pos_y));
			end
		end
	end

	task automatic test_bad_shapes();
		send_item(saa_pkg::REQ_ALLOC, 9'd0, 9'd7);
		send_item(saa_pkg::REQ_ALLOC, 9'd7, 9'd0);
		send_item(saa_pkg::REQ_ALLOC, 9'd0, 9'd0);
		send_item(saa_pkg::REQ_ALLOC, 9'd257, 9'd1);
		send_item(saa_pkg::REQ_ALLOC, 9'd1, 9'd257);
		send_item(saa_pkg::REQ_ALLOC, 9'd256, 9'd257);
		send_item(saa_pkg::REQ_ALLOC, 9'd511, 9'd511);
	endtask

	task automatic test_fill_pages();
		send_item(saa_pkg::REQ_ALLOC, 9'd256, 9'd256);
		send_item(saa_pkg::REQ_ALLOC, 9'd256, 9'd256);
		// Both pages are now solid, so even the smallest rectangle is refused.
		send_item(saa_pkg::REQ_ALLOC, 9'd1, 9'd1);
		send_item(saa_pkg::REQ_CLEAR, 9'd0, 9'd0);
	endtask

	task automatic test_window_choice();
		send_item(saa_pkg::REQ_ALLOC, 9'd1, 9'd1);
		// Only the rightmost window avoids the raised first column.
		send_item(saa_pkg::REQ_ALLOC, 9'd255, 9'd1);
		send_item(saa_pkg::REQ_ALLOC, 9'd128, 9'd10);
		send_item(saa_pkg::REQ_ALLOC, 9'd128, 9'd10);
		send_item(saa_pkg::REQ_ALLOC, 9'd1, 9'd255);
		send_item(saa_pkg::REQ_ALLOC, 9'd256, 9'd1);
		send_item(saa_pkg::REQ_CLEAR, 9'd511, 9'd511);
		send_item(saa_pkg::REQ_ALLOC, 9'd1, 9'd256);
		send_item(saa_pkg::REQ_ALLOC, 9'd1, 9'd256);
		send_item(saa_pkg::REQ_CLEAR, 9'd256, 9'd1);
	endtask

	// Mostly small rectangles so the pages build up a real skyline, with clears
	// to start over and some malformed shapes mixed in.
	task automatic test_random_traffic(input int count, input int idle_pct);
		int pick;
		sender_idle_pct = idle_pct;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 4)
				send_item(saa_pkg::REQ_CLEAR, saa_pkg::DIM_W'($urandom),
					saa_pkg::DIM_W'($urandom));
			else if (pick < 10)
				send_item(saa_pkg::REQ_ALLOC, saa_pkg::DIM_W'($urandom),
					saa_pkg::DIM_W'($urandom));
			else if (pick < 22)
				send_item(saa_pkg::REQ_ALLOC,
					saa_pkg::DIM_W'($urandom_range(1, saa_pkg::COLUMNS)),
					saa_pkg::DIM_W'($urandom_range(1, saa_pkg::ROWS)));
			else
				send_item(saa_pkg::REQ_ALLOC, saa_pkg::DIM_W'($urandom_range(1, 48)),
					saa_pkg::DIM_W'($urandom_range(1, 48)));
		end
		sender_idle_pct = 0;
	endtask

	initial begin
		clear_skyline();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_bad_shapes();
		test_fill_pages();
		test_window_choice();
		wait_for_answers();

		test_random_traffic(180, 27);
		wait_for_answers();
		test_random_traffic(180, 68);
		wait_for_answers();
		test_random_traffic(170, 0);
		wait_for_answers();

		// A full-width placement on the second page is the slowest answer, so watch
		// longer than that for stray results.
		repeat (1300) @(posedge clk);
		if (pending_answers.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("TIMEOUT: allocator stopped answering");
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
design/saa_pkg.sv
design/saa_ram.sv
design/saa_ctrl.sv
design/saa_dp.sv
design/skyline_atlas_allocator.sv
bench/skyline_atlas_allocator_tb.sv
